### hw/rtl/tga_rle_scanline_decoder_macros.svh
// assertion macros for the tga run-length scan line decoder
`ifndef TGA_RLE_SCANLINE_DECODER_MACROS_SVH
`define TGA_RLE_SCANLINE_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define TRLE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("trle assertion failed");
// next-cycle implication
`define TRLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trle assertion failed");
`else
`define TRLE_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TRLE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/trle_pkg.sv
package trle_pkg;

   // configuration defaults and register indexes
   localparam int           DEF_MAX_PIXEL_BYTES = 4;
   localparam logic [2:0]   PIXEL_BYTES_RESET   = 3'd3;
   localparam logic [15:0]  LINE_LENGTH_RESET   = 16'd640;
   localparam logic         CSR_PIXEL_BYTES     = 1'b0;
   localparam logic         CSR_LINE_LENGTH     = 1'b1;

   // packet header fields
   localparam logic [7:0]   COUNT_MASK = 8'h7f;
   localparam logic [7:0]   RUN_FLAG   = 8'h80;

   // command queue depth
   localparam int           CMD_DEPTH  = 2;
   localparam int           CMD_PTR_W  = $clog2(CMD_DEPTH);
   localparam int           CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_RAW,
      PH_RUN,
      PH_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      CMD_RAW,
      CMD_RUN,
      CMD_ERR
   } cmd_kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } back_state_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  pixel;
      logic [7:0]   count;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef struct packed {
      logic        idle;
      logic [15:0] line_done;
   } back_status_type;

endpackage

### hw/rtl/tga_rle_scanline_decoder.sv
// path: a raw pixel's command goes into the command queue, then into the output register
// throughput: one data byte per cycle unless the command queue is full; a run gives one pair result
// per cycle unless rsp_stall holds the output; a header byte is held off until the run expander and
// command queue are empty. reset: synchronous, active high; clears control state, pixel_bytes to 3
// and line_length to 640; no clearing pass
`include "tga_rle_scanline_decoder_macros.svh"

module tga_rle_scanline_decoder
   import trle_pkg::*;
#(
   parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pixel_a,
   output logic [31:0] rsp_pixel_b,
   output logic [1:0]  rsp_pair_count,
   output logic        rsp_last_of_run,
   output logic        rsp_line_end,
   output logic        rsp_overflow_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   logic [2:0]      pixel_bytes_ff, pixel_bytes_in;
   logic [15:0]     line_length_ff, line_length_in;

   logic            cmd_push;
   cmd_type         cmd_wr;
   logic            cmd_pop;
   cmd_type         cmd_rd;
   fifo_status_type fifo_stat;
   back_status_type back_stat;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      pixel_bytes_in = pixel_bytes_ff;
      line_length_in = line_length_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PIXEL_BYTES: pixel_bytes_in = csr_data[2:0];
            CSR_LINE_LENGTH: line_length_in = csr_data;
            default:         pixel_bytes_in = pixel_bytes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_bytes_ff <= PIXEL_BYTES_RESET;
         line_length_ff <= LINE_LENGTH_RESET;
      end else begin
         pixel_bytes_ff <= pixel_bytes_in;
         line_length_ff <= line_length_in;
      end
   end

   // byte parser and pixel assembler
   trle_front #(
      .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .cfg_pixel_bytes(pixel_bytes_ff),
      .cfg_line_length(line_length_ff),
      .back_status    (back_stat),
      .fifo_status    (fifo_stat),
      .cmd_push       (cmd_push),
      .cmd_data       (cmd_wr)
   );

   // command queue between parser and expander
   trle_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_data(cmd_wr),
      .pop      (cmd_pop),
      .pop_data (cmd_rd),
      .status   (fifo_stat)
   );

   // run expander, line counter and output register
   trle_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg_line_length   (line_length_ff),
      .cmd_data          (cmd_rd),
      .fifo_empty        (fifo_stat.empty),
      .cmd_pop           (cmd_pop),
      .back_status       (back_stat),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_a       (rsp_pixel_a),
      .rsp_pixel_b       (rsp_pixel_b),
      .rsp_pair_count    (rsp_pair_count),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_line_end      (rsp_line_end),
      .rsp_overflow_error(rsp_overflow_error)
   );

   // checks
   `TRLE_ASSERT_IMPLIES(a_no_push_when_full, clock, reset, cmd_push, !fifo_stat.full)
   `TRLE_ASSERT_IMPLIES(a_error_result_form, clock, reset, rsp_valid && rsp_overflow_error, (rsp_pair_count == 2'd0) && rsp_last_of_run && !rsp_line_end)
   `TRLE_ASSERT_IMPLIES(a_pair_same_pixel, clock, reset, rsp_valid && (rsp_pair_count == 2'd2), rsp_pixel_b == rsp_pixel_a)
   `TRLE_ASSERT_NEXT(a_pop_fills_output, clock, reset, cmd_pop, rsp_valid)

endmodule

### hw/rtl/trle_front.sv
module trle_front
   import trle_pkg::*;
#(
   parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [7:0]      req_data_byte,
   input  logic [2:0]      cfg_pixel_bytes,
   input  logic [15:0]     cfg_line_length,
   input  back_status_type back_status,
   input  fifo_status_type fifo_status,
   output logic            cmd_push,
   output cmd_type         cmd_data
);

   localparam int BIP_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
   localparam int PB_W  = $clog2(MAX_PIXEL_BYTES + 1);

   phase_type          phase_ff, phase_in;
   logic [7:0]         left_ff, left_in;
   logic [BIP_W-1:0]   bip_ff, bip_in;
   logic [31:0]        asm_ff, asm_in;

   logic               ready;
   logic               accept;
   logic [PB_W-1:0]    eff_pb;
   logic [PB_W-1:0]    bip_cnt;
   logic               pixel_done;
   logic [31:0]        asm_next;
   logic [7:0]         hdr_count;
   logic               overrun;
   logic [7:0]         left_dec;

   // effective pixel size, clamped to 1..MAX_PIXEL_BYTES
   always_comb begin
      if (int'(cfg_pixel_bytes) > MAX_PIXEL_BYTES) begin
         eff_pb = PB_W'(MAX_PIXEL_BYTES);
      end else if (cfg_pixel_bytes == 3'd0) begin
         eff_pb = PB_W'(1);
      end else begin
         eff_pb = PB_W'(cfg_pixel_bytes);
      end
   end

   assign bip_cnt    = PB_W'(bip_ff) + PB_W'(1);
   assign pixel_done = (bip_cnt >= eff_pb);
   assign left_dec   = (left_ff != 8'd0) ? (left_ff - 8'd1) : 8'd0;

   // header decode and overrun check against the back end's line count
   assign hdr_count = (req_data_byte & COUNT_MASK) + 8'd1;
   assign overrun   = ({1'b0, back_status.line_done} + {9'd0, hdr_count})
                      > {1'b0, cfg_line_length};

   // byte lane insertion, bytes beyond the 32-bit pixel are dropped
   always_comb begin
      asm_next = asm_ff;
      for (int k = 0; k < 4; k++) begin
         if (int'(bip_ff) == k) begin
            asm_next[8*k +: 8] = asm_ff[8*k +: 8] | req_data_byte;
         end
      end
   end

   // headers wait for the back end to drain so the line count is final
   always_comb begin
      unique case (phase_ff)
         PH_HEADER:      ready = back_status.idle;
         PH_RAW, PH_RUN: ready = !fifo_status.full;
         PH_SKIP:        ready = 1'b1;
         default:        ready = 1'b0;
      endcase
   end

   assign req_stall = !ready;
   assign accept    = req_valid && ready;

   // next state and command generation
   always_comb begin
      phase_in       = phase_ff;
      left_in        = left_ff;
      bip_in         = bip_ff;
      asm_in         = asm_ff;
      cmd_push       = 1'b0;
      cmd_data.kind  = CMD_RAW;
      cmd_data.pixel = asm_next;
      cmd_data.count = left_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               bip_in = '0;
               if (overrun) begin
                  cmd_push       = 1'b1;
                  cmd_data.kind  = CMD_ERR;
                  cmd_data.pixel = '0;
                  cmd_data.count = '0;
                  left_in  = ((req_data_byte & RUN_FLAG) != 8'd0) ? 8'd1 : hdr_count;
                  phase_in = PH_SKIP;
               end else begin
                  left_in  = hdr_count;
                  asm_in   = '0;
                  phase_in = ((req_data_byte & RUN_FLAG) != 8'd0) ? PH_RUN : PH_RAW;
               end
            end
            PH_RAW, PH_RUN: begin
               if (pixel_done) begin
                  bip_in        = '0;
                  asm_in        = '0;
                  cmd_push      = 1'b1;
                  cmd_data.kind = (phase_ff == PH_RUN) ? CMD_RUN : CMD_RAW;
                  if (phase_ff == PH_RUN) begin
                     left_in  = 8'd0;
                     phase_in = PH_HEADER;
                  end else begin
                     left_in = left_dec;
                     if (left_dec == 8'd0) begin
                        phase_in = PH_HEADER;
                     end
                  end
               end else begin
                  bip_in = BIP_W'(bip_cnt);
                  asm_in = asm_next;
               end
            end
            PH_SKIP: begin
               if (pixel_done) begin
                  bip_in  = '0;
                  left_in = left_dec;
                  if (left_dec == 8'd0) begin
                     phase_in = PH_HEADER;
                  end
               end else begin
                  bip_in = BIP_W'(bip_cnt);
               end
            end
            default: phase_in = PH_HEADER;
         endcase
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // packet and pixel assembly registers
   always_ff @(posedge clock) begin
      left_ff <= left_in;
      bip_ff  <= bip_in;
      asm_ff  <= asm_in;
   end

endmodule

### hw/rtl/trle_cmd_fifo.sv
module trle_cmd_fifo
   import trle_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  cmd_type         push_data,
   input  logic            pop,
   output cmd_type         pop_data,
   output fifo_status_type status
);

   cmd_type                entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign pop_data     = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == CMD_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == CMD_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/trle_back.sv
module trle_back
   import trle_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [15:0]     cfg_line_length,
   input  cmd_type         cmd_data,
   input  logic            fifo_empty,
   output logic            cmd_pop,
   output back_status_type back_status,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [31:0]     rsp_pixel_a,
   output logic [31:0]     rsp_pixel_b,
   output logic [1:0]      rsp_pair_count,
   output logic            rsp_last_of_run,
   output logic            rsp_line_end,
   output logic            rsp_overflow_error
);

   back_state_type state_ff, state_in;
   logic [15:0]    done_ff, done_in;
   logic [31:0]    run_px_ff, run_px_in;
   logic [7:0]     run_left_ff, run_left_in;

   logic           valid_ff, valid_in;
   logic [31:0]    pix_a_ff, pix_a_in;
   logic [31:0]    pix_b_ff, pix_b_in;
   logic [1:0]     cnt_ff, cnt_in;
   logic           last_ff, last_in;
   logic           lend_ff, lend_in;
   logic           err_ff, err_in;

   logic           load_ok;
   logic           go;
   cmd_kind_type   kind;
   logic [31:0]    src_px;
   logic [7:0]     src_left;
   logic           two;
   logic [7:0]     left_rem;
   logic [15:0]    d1_raw, d1, d2_raw, d2;
   logic           lend1, lend2;

   assign load_ok = !valid_ff || !rsp_stall;

   // source select: ongoing run or head of the queue
   always_comb begin
      if (state_ff == BK_RUN) begin
         kind     = CMD_RUN;
         src_px   = run_px_ff;
         src_left = run_left_ff;
         go       = load_ok;
         cmd_pop  = 1'b0;
      end else begin
         kind     = cmd_data.kind;
         src_px   = cmd_data.pixel;
         src_left = cmd_data.count;
         go       = load_ok && !fifo_empty;
         cmd_pop  = go;
      end
   end

   // pair size and line position after one and two pixels
   assign two      = (src_left >= 8'd2);
   assign left_rem = src_left - (two ? 8'd2 : 8'd1);
   assign d1_raw   = done_ff + 16'd1;
   assign lend1    = (d1_raw >= cfg_line_length);
   assign d1       = lend1 ? 16'd0 : d1_raw;
   assign d2_raw   = d1 + 16'd1;
   assign lend2    = (d2_raw >= cfg_line_length);
   assign d2       = lend2 ? 16'd0 : d2_raw;

   // result formation and run expansion
   always_comb begin
      state_in    = state_ff;
      done_in     = done_ff;
      run_px_in   = run_px_ff;
      run_left_in = run_left_ff;
      valid_in    = valid_ff && rsp_stall;
      pix_a_in    = pix_a_ff;
      pix_b_in    = pix_b_ff;
      cnt_in      = cnt_ff;
      last_in     = last_ff;
      lend_in     = lend_ff;
      err_in      = err_ff;
      if (go) begin
         valid_in = 1'b1;
         unique case (kind)
            CMD_ERR: begin
               pix_a_in = '0;
               pix_b_in = '0;
               cnt_in   = 2'd0;
               last_in  = 1'b1;
               lend_in  = 1'b0;
               err_in   = 1'b1;
               done_in  = '0;
            end
            CMD_RAW: begin
               pix_a_in = src_px;
               pix_b_in = '0;
               cnt_in   = 2'd1;
               last_in  = 1'b1;
               lend_in  = lend1;
               err_in   = 1'b0;
               done_in  = d1;
            end
            CMD_RUN: begin
               pix_a_in    = src_px;
               pix_b_in    = two ? src_px : 32'd0;
               cnt_in      = two ? 2'd2 : 2'd1;
               last_in     = (left_rem == 8'd0);
               lend_in     = lend1 || (two && lend2);
               err_in      = 1'b0;
               done_in     = two ? d2 : d1;
               run_px_in   = src_px;
               run_left_in = left_rem;
               state_in    = (left_rem != 8'd0) ? BK_RUN : BK_IDLE;
            end
            default: begin
               valid_in = 1'b0;
            end
         endcase
      end
   end

   assign back_status.idle      = (state_ff == BK_IDLE) && fifo_empty;
   assign back_status.line_done = done_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   // run and output payload
   always_ff @(posedge clock) begin
      run_px_ff   <= run_px_in;
      run_left_ff <= run_left_in;
      pix_a_ff    <= pix_a_in;
      pix_b_ff    <= pix_b_in;
      cnt_ff      <= cnt_in;
      last_ff     <= last_in;
      lend_ff     <= lend_in;
      err_ff      <= err_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_pixel_a        = pix_a_ff;
   assign rsp_pixel_b        = pix_b_ff;
   assign rsp_pair_count     = cnt_ff;
   assign rsp_last_of_run    = last_ff;
   assign rsp_line_end       = lend_ff;
   assign rsp_overflow_error = err_ff;

endmodule

### bench/tga_rle_scanline_decoder_test.sv
module tga_rle_scanline_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import trle_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_HOLD  = 8;

   // one decoded result as seen on the rsp channel
   typedef struct packed {
      logic [31:0] pixel_a;
      logic [31:0] pixel_b;
      logic [1:0]  pair_count;
      logic        last_of_run;
      logic        line_end;
      logic        overflow_error;
   } decoded_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_pixel_a;
   logic [31:0] rsp_pixel_b;
   logic [1:0]  rsp_pair_count;
   logic        rsp_last_of_run;
   logic        rsp_line_end;
   logic        rsp_overflow_error;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_PIXEL_BYTES;
   logic [15:0] csr_data = 16'h0000;

   // stream bytes waiting to be sent and results waiting to arrive
   logic [7:0]         byte_queue[$];
   decoded_result_type pending_results[$];
   int unsigned        bytes_queued = 0;
   int unsigned        failures = 0;
   int unsigned        cycle_count = 0;
   int unsigned        idle_pct = 26;
   int unsigned        line_guess = 0;

   // decoder state and register copies
   logic [2:0]  cfg_pixel_bytes = PIXEL_BYTES_RESET;
   logic [15:0] cfg_line_length = LINE_LENGTH_RESET;
   phase_type   dec_phase = PH_HEADER;
   logic [7:0]  dec_left = 8'd0;
   logic [2:0]  dec_byte_idx = 3'd0;
   logic [31:0] dec_assembly = 32'd0;
   logic [15:0] line_done = 16'd0;

   tga_rle_scanline_decoder i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_a        (rsp_pixel_a),
      .rsp_pixel_b        (rsp_pixel_b),
      .rsp_pair_count     (rsp_pair_count),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_line_end       (rsp_line_end),
      .rsp_overflow_error (rsp_overflow_error),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tga_rle_scanline_decoder test failed");
         $finish;
      end
   end

   function automatic int unsigned effective_pixel_bytes(input logic [2:0] pb);
      if (pb == 3'd0) return 1;
      if (pb > DEF_MAX_PIXEL_BYTES) return DEF_MAX_PIXEL_BYTES;
      return 32'(pb);
   endfunction

   // counts one pixel into the line, returns 1 when the line completes
   function automatic logic count_line_pixel();
      line_done = line_done + 16'd1;
      if (line_done >= cfg_line_length) begin
         line_done = 16'd0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // expected results of one accepted stream byte
   task automatic decode_byte(input logic [7:0] b);
      int unsigned pbe;
      int unsigned count;
      int unsigned left;
      int unsigned cnt;
      int unsigned n;
      logic [31:0] px;
      logic        lend;
      logic        lend2;
      pbe = effective_pixel_bytes(cfg_pixel_bytes);
      case (dec_phase)
         PH_HEADER: begin
            count = (b & COUNT_MASK) + 1;
            if (32'(line_done) + count > 32'(cfg_line_length)) begin
               // packet overruns the line: error result, data skipped
               pending_results.push_back('{pixel_a: 32'd0, pixel_b: 32'd0, pair_count: 2'd0,
                  last_of_run: 1'b1, line_end: 1'b0, overflow_error: 1'b1});
               line_done = 16'd0;
               dec_left = ((b & RUN_FLAG) != 0) ? 8'd1 : 8'(count);
               dec_byte_idx = 3'd0;
               dec_phase = PH_SKIP;
            end else begin
               dec_left = 8'(count);
               dec_byte_idx = 3'd0;
               dec_assembly = 32'd0;
               dec_phase = ((b & RUN_FLAG) != 0) ? PH_RUN : PH_RAW;
            end
         end
         PH_SKIP: begin
            dec_byte_idx = dec_byte_idx + 3'd1;
            if (dec_byte_idx >= pbe) begin
               dec_byte_idx = 3'd0;
               if (dec_left > 0) dec_left = dec_left - 8'd1;
               if (dec_left == 0) dec_phase = PH_HEADER;
            end
         end
         default: begin
            dec_assembly = dec_assembly | (32'(b) << (8 * dec_byte_idx));
            dec_byte_idx = dec_byte_idx + 3'd1;
            if (dec_byte_idx >= pbe) begin
               px = dec_assembly;
               dec_byte_idx = 3'd0;
               dec_assembly = 32'd0;
               if (dec_phase == PH_RAW) begin
                  lend = count_line_pixel();
                  pending_results.push_back('{pixel_a: px, pixel_b: 32'd0, pair_count: 2'd1,
                     last_of_run: 1'b1, line_end: lend, overflow_error: 1'b0});
                  if (dec_left > 0) dec_left = dec_left - 8'd1;
                  if (dec_left == 0) dec_phase = PH_HEADER;
               end else begin
                  // run pixel expands into pairs, a single one last when odd
                  left = dec_left;
                  n = 0;
                  while (left > 0 && n < 64) begin
                     cnt = (left >= 2) ? 2 : 1;
                     lend = count_line_pixel();
                     if (cnt == 2) begin
                        lend2 = count_line_pixel();
                        lend = lend | lend2;
                     end
                     left = left - cnt;
                     pending_results.push_back('{pixel_a: px,
                        pixel_b: (cnt == 2) ? px : 32'd0, pair_count: 2'(cnt),
                        last_of_run: (left == 0), line_end: lend, overflow_error: 1'b0});
                     n++;
                  end
                  dec_left = 8'd0;
                  dec_phase = PH_HEADER;
               end
            end
         end
      endcase
   endtask

   // stream driver
   always @(posedge clock) begin : byte_driver
      logic       next_valid;
      logic [7:0] next_byte;
      next_valid = req_valid;
      next_byte = req_data_byte;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_data_byte);
            void'(byte_queue.pop_front());
            next_valid = 1'b0;
         end
         if (!next_valid && byte_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
            next_valid = 1'b1;
            next_byte = byte_queue[0];
         end
      end
      req_valid <= next_valid;
      req_data_byte <= next_byte;
   end

   // result monitor
   always @(posedge clock) begin : result_monitor
      decoded_result_type seen;
      decoded_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{pixel_a: rsp_pixel_a, pixel_b: rsp_pixel_b, pair_count: rsp_pair_count,
            last_of_run: rsp_last_of_run, line_end: rsp_line_end,
            overflow_error: rsp_overflow_error};
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transaction a=%h b=%h cnt=%0d last=%b lend=%b err=%b",
               $time, seen.pixel_a, seen.pixel_b, seen.pair_count, seen.last_of_run,
               seen.line_end, seen.overflow_error);
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (seen !== want) begin
               $display("%0t: mismatch expected a=%h b=%h cnt=%0d last=%b lend=%b err=%b",
                  $time, want.pixel_a, want.pixel_b, want.pair_count, want.last_of_run,
                  want.line_end, want.overflow_error);
               $display("%0t:          actual a=%h b=%h cnt=%0d last=%b lend=%b err=%b",
                  $time, seen.pixel_a, seen.pixel_b, seen.pair_count, seen.last_of_run,
                  seen.line_end, seen.overflow_error);
               failures++;
            end
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < idle_pct);
   end

   task automatic queue_byte(input logic [7:0] b);
      byte_queue.push_back(b);
      bytes_queued++;
   endtask

   // register write, model copy updated on the handshake
   task automatic write_register(input logic idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_PIXEL_BYTES) cfg_pixel_bytes = value[2:0];
      else cfg_line_length = value;
      csr_valid <= 1'b0;
   endtask

   // pixel size with random upper bits, which the register drops
   task automatic set_config(input logic [2:0] pb, input logic [15:0] ll);
      write_register(CSR_PIXEL_BYTES, {13'($urandom), pb});
      write_register(CSR_LINE_LENGTH, ll);
   endtask

   // wait until every byte is taken and every result has come back
   task automatic wait_drained();
      while (byte_queue.size() != 0 || pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_HOLD) @(posedge clock);
   endtask

   // one packet: mostly fitting the line, some overruns, some noise bytes
   task automatic add_packet(input int unsigned pbe, input int unsigned ll);
      int unsigned kind;
      int unsigned room;
      int unsigned cap;
      int unsigned count;
      int unsigned npix;
      logic        is_run;
      kind = $urandom_range(99);
      room = (ll > line_guess) ? ll - line_guess : 0;
      is_run = 1'($urandom_range(1));
      if (kind < 10) begin
         repeat ($urandom_range(3, 1)) queue_byte(8'($urandom_range(255)));
         return;
      end
      if ((kind < 22 && room < 128) || room == 0) begin
         count = $urandom_range((room + 4 > 128) ? 128 : room + 4, room + 1);
         if (count > 8) is_run = 1'b1;
         line_guess = 0;
      end else begin
         cap = (room > 128) ? 128 : room;
         if (!is_run && cap > 6) cap = 6;
         else if (is_run && cap > 8 && $urandom_range(2) != 0) cap = 8;
         count = $urandom_range(cap, 1);
         line_guess = line_guess + count;
         if (line_guess >= ll) line_guess = 0;
      end
      queue_byte({is_run, 7'(count - 1)});
      npix = is_run ? 1 : count;
      repeat (npix * pbe) queue_byte(8'($urandom_range(255)));
   endtask

   task automatic random_phase(input logic [2:0] pb, input logic [15:0] ll,
         input int unsigned budget);
      int unsigned start;
      int unsigned pbe;
      set_config(pb, ll);
      pbe = effective_pixel_bytes(pb);
      line_guess = 32'(line_done);
      start = bytes_queued;
      while (bytes_queued - start < budget) add_packet(pbe, 32'(ll));
      wait_drained();
   endtask

   // stimulus
   initial begin : stimulus
      logic [2:0]  pb_list[6];
      logic [15:0] ll_list[6];
      pb_list = '{3'd2, 3'd4, 3'd1, 3'd3, 3'd6, 3'd4};
      ll_list = '{16'd16, 16'd1, 16'd7, 16'd65535, 16'd9, 16'd3};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: longest run, raw extremes, run of two
      queue_byte(8'hff);
      queue_byte(8'ha5);
      queue_byte(8'h5a);
      queue_byte(8'h3c);
      queue_byte(8'h00);
      queue_byte(8'hff);
      queue_byte(8'hff);
      queue_byte(8'hff);
      queue_byte(8'h81);
      queue_byte(8'h00);
      queue_byte(8'h00);
      queue_byte(8'h00);
      wait_drained();

      // one-byte pixels, four-pixel lines: overrun, line end, odd run, raw overrun
      set_config(3'd1, 16'd4);
      queue_byte(8'h84);
      queue_byte(8'h55);
      queue_byte(8'h03);
      queue_byte(8'h11);
      queue_byte(8'h22);
      queue_byte(8'h33);
      queue_byte(8'h44);
      queue_byte(8'h82);
      queue_byte(8'h66);
      queue_byte(8'h01);
      queue_byte(8'h77);
      queue_byte(8'h88);
      wait_drained();

      // pixel size zero and line length zero
      set_config(3'd0, 16'd0);
      queue_byte(8'h00);
      queue_byte(8'h99);
      wait_drained();

      // oversized pixel size, longest line
      set_config(3'd7, 16'd65535);
      queue_byte(8'h00);
      queue_byte(8'h01);
      queue_byte(8'h02);
      queue_byte(8'h03);
      queue_byte(8'h04);
      wait_drained();

      // random packets under several settings, one phase without idling
      foreach (pb_list[p]) begin
         idle_pct = (p == 3) ? 0 : 26;
         random_phase(pb_list[p], ll_list[p], 12);
      end
      idle_pct = 26;

      wait_drained();
      if (failures == 0 && pending_results.size() == 0) begin
         $display("tga_rle_scanline_decoder test passed");
      end else begin
         $display("tga_rle_scanline_decoder test failed");
      end
      $finish;
   end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/trle_pkg.sv
hw/rtl/trle_front.sv
hw/rtl/trle_cmd_fifo.sv
hw/rtl/trle_back.sv
hw/rtl/tga_rle_scanline_decoder.sv
bench/tga_rle_scanline_decoder_test.sv
